// ===== rtl/sqlte_pkg.sv =====
// ----------------------------------------------------------------------------
// sqlte_pkg
// Shared types, constants and the month table for the date-time text to
// epoch seconds converter.
// ----------------------------------------------------------------------------
package sqlte_pkg;

  localparam int RUN_W      = 14;
  localparam int NUM_FIELDS = 6;
  localparam int CNT_W      = 3;
  localparam int EPOCH_W    = 31;
  localparam int DAYS_W     = 22;
  localparam int TSUM_W     = 26;
  localparam int Q100_W     = 7;
  localparam int MONTH_W    = 4;
  localparam int CUM_W      = 9;

  localparam logic [RUN_W-1:0]   RUN_MAX    = 14'd9999;
  localparam int                 EPOCH_YEAR = 1970;
  localparam int                 LEAPS_BEFORE_EPOCH =
      (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100 + (EPOCH_YEAR - 1) / 400;
  localparam int                 DAYS_PER_YEAR = 365;
  localparam int                 SECS_PER_DAY  = 86400;
  localparam int                 SECS_PER_HOUR = 3600;
  localparam int                 SECS_PER_MIN  = 60;
  localparam int                 RECIP_100     = 5243;
  localparam int                 RECIP_SHIFT   = 19;
  localparam logic [EPOCH_W-1:0] RESULT_MAX    = '1;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef logic [RUN_W-1:0] run_t;
  typedef logic [NUM_FIELDS-1:0][RUN_W-1:0] fields_t;

  // days before the first of the given month, common year
  function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] month);
    logic [CUM_W-1:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/sql_datetime_text_to_epoch_core.sv =====
// ----------------------------------------------------------------------------
// sql_datetime_text_to_epoch_core
// Converts a date-time text, one character per item, to Unix epoch seconds.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------
//   input   | in_valid / in_ready   | text_char[7:0], final_char
//   output  | out_valid / out_ready | epoch_seconds[30:0], date_present
//
// One character per cycle while in_ready is high. A final character's result
// passes the stage registers for year division, day count and seconds scale
// and then the output register before it shows on out_valid.
// Synchronous reset empties the pipeline and clears the scanner.
// A stalled output fills the three arithmetic stages; in_ready falls only
// when all of them and the output register hold a result.
// ----------------------------------------------------------------------------
module sql_datetime_text_to_epoch_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    text_char,
  input  logic                          final_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sqlte_pkg::EPOCH_W-1:0] epoch_seconds,
  output logic                          date_present
);
  import sqlte_pkg::*;

  logic    accept;
  fields_t fields;

  assign accept = in_valid && in_ready;

  sqlte_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_char  (text_char),
    .final_char (final_char),
    .fields     (fields)
  );

  sqlte_calc u_calc (
    .clk           (clk),
    .rst           (rst),
    .push          (accept && final_char),
    .push_ready    (in_ready),
    .fields        (fields),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .epoch_seconds (epoch_seconds),
    .date_present  (date_present)
  );

endmodule

// ===== rtl/sqlte_parse.sv =====
// ----------------------------------------------------------------------------
// sqlte_parse
// Character scanner: collects digit runs into up to six field values and
// hands the closed set of fields out on the last character of a text.
// ----------------------------------------------------------------------------
module sqlte_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        text_char,
  input  logic              final_char,
  output sqlte_pkg::fields_t fields
);
  import sqlte_pkg::*;

  run_t             acc;
  logic [CNT_W-1:0] cnt;
  logic             in_run;
  fields_t          fv;

  logic             is_digit;
  logic [3:0]       digit;
  logic [RUN_W+3:0] acc_mul;
  run_t             acc_new;
  run_t             close_val;
  logic             do_close;
  logic             room;
  fields_t          fields_closed;
  logic [CNT_W-1:0] cnt_closed;

  always_comb begin
    is_digit  = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);
    digit     = 4'(text_char - CHAR_ZERO);
    acc_mul   = {acc, 3'b000} + {2'b00, acc, 1'b0} + (RUN_W+4)'(digit);
    acc_new   = (acc_mul > (RUN_W+4)'(RUN_MAX)) ? RUN_MAX : acc_mul[RUN_W-1:0];
    close_val = is_digit ? acc_new : acc;
    do_close  = is_digit ? final_char : in_run;
    room      = cnt < CNT_W'(NUM_FIELDS);
    fields_closed = fv;
    cnt_closed    = cnt;
    if (do_close && room) begin
      fields_closed[cnt] = close_val;
      cnt_closed         = cnt + CNT_W'(1);
    end
  end

  assign fields = fields_closed;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      cnt    <= '0;
      in_run <= 1'b0;
      fv     <= '0;
    end else if (accept) begin
      if (final_char) begin
        acc    <= '0;
        cnt    <= '0;
        in_run <= 1'b0;
        fv     <= '0;
      end else begin
        acc    <= is_digit ? acc_new : '0;
        cnt    <= cnt_closed;
        in_run <= is_digit;
        fv     <= fields_closed;
      end
    end
  end

endmodule

// ===== rtl/sqlte_calc.sv =====
// ----------------------------------------------------------------------------
// sqlte_calc
// Three-stage epoch arithmetic with an output register. Stage one divides
// the year by 100, stage two forms day count and time of day, stage three
// scales days to seconds and saturates.
// ----------------------------------------------------------------------------
module sqlte_calc (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         push_ready,
  input  sqlte_pkg::fields_t           fields,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sqlte_pkg::EPOCH_W-1:0] epoch_seconds,
  output logic                         date_present
);
  import sqlte_pkg::*;

  localparam int QP_W  = RUN_W + 13;
  localparam int SUM_W = 24;
  localparam int PRD_W = DAYS_W + 17;
  localparam int TOT_W = PRD_W + 1;

  logic v1, v2, v3;
  logic en_o, en3, en2, en1;

  assign en_o       = !out_valid || out_ready;
  assign en3        = !v3 || en_o;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign push_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)  v1        <= push;
      if (en2)  v2        <= v1;
      if (en3)  v3        <= v2;
      if (en_o) out_valid <= v3;
    end
  end

  // stage 1
  fields_t          f1;
  logic             date1;
  run_t             ym1_1;
  logic [QP_W-1:0]  qprod;
  logic [MONTH_W-1:0] month1;

  always_ff @(posedge clk) begin
    if (en1) f1 <= fields;
  end

  always_comb begin
    date1 = f1[0] >= RUN_W'(EPOCH_YEAR);
    ym1_1 = f1[0] - RUN_W'(1);
    qprod = QP_W'(ym1_1) * QP_W'(RECIP_100);
    if (f1[1] < RUN_W'(1))       month1 = MONTH_W'(1);
    else if (f1[1] > RUN_W'(12)) month1 = MONTH_W'(12);
    else                         month1 = f1[1][MONTH_W-1:0];
  end

  // stage 2
  logic               date2;
  run_t               ym1_2;
  logic [Q100_W-1:0]  q100_2;
  logic [MONTH_W-1:0] month2;
  run_t               day2, hr2, mn2, sc2;

  always_ff @(posedge clk) begin
    if (en2) begin
      date2  <= date1;
      ym1_2  <= ym1_1;
      q100_2 <= qprod[RECIP_SHIFT+Q100_W-1:RECIP_SHIFT];
      month2 <= month1;
      day2   <= f1[2];
      hr2    <= date1 ? f1[3] : f1[0];
      mn2    <= date1 ? f1[4] : f1[1];
      sc2    <= date1 ? f1[5] : f1[2];
    end
  end

  run_t              rem100;
  logic              r99;
  logic              leap;
  logic [SUM_W-1:0]  yoff;
  logic [SUM_W-1:0]  days_sum;
  logic [DAYS_W-1:0] days_c;
  logic [TSUM_W-1:0] tsum;

  always_comb begin
    // y = ym1 + 1; y % 100 == 0 exactly when ym1 % 100 == 99
    rem100 = ym1_2 - RUN_W'(q100_2) * RUN_W'(100);
    r99    = rem100 == RUN_W'(99);
    leap   = ((ym1_2[1:0] == 2'd3) && !r99) || (r99 && (q100_2[1:0] == 2'd3));
    yoff   = SUM_W'(ym1_2) - SUM_W'(EPOCH_YEAR - 1);
    days_sum = yoff * SUM_W'(DAYS_PER_YEAR)
             + SUM_W'(ym1_2[RUN_W-1:2])
             - SUM_W'(q100_2)
             + SUM_W'(q100_2[Q100_W-1:2])
             - SUM_W'(LEAPS_BEFORE_EPOCH)
             + SUM_W'(cum_days(month2))
             + SUM_W'(leap && (month2 > MONTH_W'(2)))
             + SUM_W'(day2)
             - SUM_W'(1);
    if (!date2 || days_sum[SUM_W-1]) days_c = '0;
    else                              days_c = days_sum[DAYS_W-1:0];
    tsum = TSUM_W'(hr2) * TSUM_W'(SECS_PER_HOUR)
         + TSUM_W'(mn2) * TSUM_W'(SECS_PER_MIN)
         + TSUM_W'(sc2);
  end

  // stage 3
  logic              date3;
  logic [DAYS_W-1:0] days3;
  logic [TSUM_W-1:0] tsum3;
  logic [PRD_W-1:0]  dprod;
  logic [TOT_W-1:0]  total;

  always_ff @(posedge clk) begin
    if (en3) begin
      date3 <= date2;
      days3 <= days_c;
      tsum3 <= tsum;
    end
  end

  always_comb begin
    dprod = PRD_W'(days3) * PRD_W'(SECS_PER_DAY);
    total = TOT_W'(dprod) + TOT_W'(tsum3);
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      date_present  <= date3;
      epoch_seconds <= (total > TOT_W'(RESULT_MAX)) ? RESULT_MAX
                                                    : total[EPOCH_W-1:0];
    end
  end

endmodule

// ===== rtl/sqlte_checker.sv =====
// ----------------------------------------------------------------------------
// sqlte_checker
// Port-level checks for the date-time to epoch converter, bound to the top.
// ----------------------------------------------------------------------------
module sqlte_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [7:0]                    text_char,
  input logic                          final_char,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sqlte_pkg::EPOCH_W-1:0] epoch_seconds,
  input logic                          date_present
);
  import sqlte_pkg::*;

  // largest time-of-day sum from three saturated runs
  localparam logic [EPOCH_W-1:0] TIME_ONLY_MAX = EPOCH_W'(
      9999 * SECS_PER_HOUR + 9999 * SECS_PER_MIN + 9999);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=>
      in_valid && $stable(text_char) && $stable(final_char))
    else $error("input item changed while waiting");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(epoch_seconds) && $stable(date_present))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_time_only_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !date_present |-> epoch_seconds <= TIME_ONLY_MAX)
    else $error("time-only result out of range");

endmodule

bind sql_datetime_text_to_epoch_core sqlte_checker u_sqlte_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .text_char     (text_char),
  .final_char    (final_char),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .epoch_seconds (epoch_seconds),
  .date_present  (date_present)
);
